@@ hdl/frst_pkg.sv @@
// Package for the framed register table slave: shared types, codes and constants.
// No dependencies; used by frst_front, frst_back and the top level (frst_ram does not use it).
`default_nettype none

package frst_pkg;

  localparam int TABLE_BYTES     = 256;
  localparam int FRAME_BYTES     = 256;
  localparam int PASSWORD_OFFSET = 0;
  localparam int TABLE_DEPTH     = 256;

  localparam logic [7:0] SOF      = 8'h68;
  localparam logic [7:0] EOF_MARK = 8'h16;
  localparam logic [7:0] ADDR0    = 8'h31;
  localparam logic [7:0] ADDR1    = 8'hCE;
  localparam logic [7:0] BIAS     = 8'h33;

  localparam logic [7:0] CMD_READ   = 8'h02;
  localparam logic [7:0] CMD_WRITE  = 8'h04;
  localparam logic [7:0] CMD_RESET  = 8'hF6;
  localparam logic [7:0] RSP_READ   = 8'h82;
  localparam logic [7:0] RSP_RD_ERR = 8'hC2;
  localparam logic [7:0] RSP_WRITE  = 8'h84;
  localparam logic [7:0] RSP_WR_ERR = 8'hC4;
  localparam logic [7:0] ERR_RANGE  = 8'h40;
  localparam logic [7:0] ERR_PASSWD = 8'h11;

  // sum of the four fixed header bytes 68 31 CE 68, modulo 256
  localparam logic [7:0] HDR_SUM = 8'(SOF + ADDR0 + ADDR1 + SOF);

  localparam logic [1:0] IN_RX    = 2'd0;
  localparam logic [1:0] IN_FETCH = 2'd1;
  localparam logic [1:0] IN_CLEAR = 2'd2;
  localparam logic [1:0] IN_NOP   = 2'd3;

  typedef enum logic [1:0] {
    OP_RX,
    OP_FETCH,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_PW_RD,
    S_PW_CHK,
    S_WR_RD,
    S_WR_DO,
    S_TX_OUT
  } st_e;

endpackage

`default_nettype wire

@@ hdl/frst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module frst_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/frst_front.sv @@
// Front end: takes input words, classifies the command and queues them (two deep).
// Depends on frst_pkg.
`default_nettype none

module frst_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    command_i,
  input  wire logic [7:0]    rx_byte_i,
  output logic               q_valid_o,
  output frst_pkg::item_t    q_item_o,
  input  wire logic          q_pop_i
);
  import frst_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      item_in;

  assign in_stall_o = (cnt_q == 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    item_in.data = rx_byte_i;
    case (command_i)
      IN_RX:    item_in.op = OP_RX;
      IN_FETCH: item_in.op = OP_FETCH;
      default:  item_in.op = OP_CLEAR;
    endcase
  end

  // command 3 is accepted and dropped
  assign push = in_valid_i && !in_stall_o && (command_i != IN_NOP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

@@ hdl/frst_back.sv @@
// Back end: frame receiver, command engine over the parameter table, reply sender.
// Depends on frst_pkg and frst_ram.
`default_nettype none

module frst_back #(
  parameter int FrameBytes = frst_pkg::FRAME_BYTES
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire frst_pkg::item_t q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         tx_byte_o,
  output logic               tx_valid_o,
  output logic               tx_last_o,
  output logic [2:0]         sync_flags_o
);
  import frst_pkg::*;

  localparam int FrameAw = $clog2(FrameBytes);

  st_e        st_q, st_d;
  logic [7:0] rx_cnt_q, rx_cnt_d;
  logic [7:0] fb1_q, fb1_d, fb2_q, fb2_d, cmd_q, cmd_d, len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic       chk_q, chk_d;
  logic [7:0] d_q [6];
  logic [7:0] d_d [6];

  logic [7:0] code_q, code_d, start_q, start_d, rlen_q, rlen_d, err_q, err_d;
  logic [7:0] rsum_q, rsum_d;
  logic [8:0] pos_q, pos_d;
  logic       pend_q, pend_d;
  logic [2:0] flags_q, flags_d;

  logic [7:0] k_q, k_d, addr_q, addr_d, cnt_q, cnt_d, acc_q, acc_d;

  logic       out_vq, out_vd;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_tv_q, out_tv_d, out_last_q, out_last_d;
  logic [2:0] out_flags_q, out_flags_d;

  logic               fr_we;
  logic [FrameAw-1:0] fr_waddr, fr_raddr;
  logic [7:0]         fr_rdata;
  logic               tb_we;
  logic [7:0]         tb_waddr, tb_wdata, tb_raddr, tb_rdata, tb_data;
  logic               tv_q [TABLE_DEPTH];
  logic               tvr_q;

  logic       emit;
  logic [7:0] emit_byte;
  logic [7:0] b, f1, f2, rd_addr, rd_cnt, wval, wa;
  logic [8:0] n, ix12;

  frst_ram #(.Width(8), .Depth(FrameBytes)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (q_item_i.data),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  frst_ram #(.Width(8), .Depth(TABLE_DEPTH)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (tb_waddr),
    .wdata_i (tb_wdata),
    .raddr_i (tb_raddr),
    .rdata_o (tb_rdata)
  );

  // entries never written since reset read as zero
  assign tb_data = tvr_q ? tb_rdata : 8'h00;

  assign b       = q_item_i.data;
  assign rd_addr = d_q[0] - BIAS;
  assign rd_cnt  = d_q[1] - BIAS;
  assign ix12    = 9'd12 + {1'b0, k_q};
  assign wa      = addr_q + k_q;

  always_comb begin
    st_d     = st_q;
    rx_cnt_d = rx_cnt_q;
    fb1_d    = fb1_q;
    fb2_d    = fb2_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    sum_d    = sum_q;
    chk_d    = chk_q;
    d_d      = d_q;
    code_d   = code_q;
    start_d  = start_q;
    rlen_d   = rlen_q;
    err_d    = err_q;
    rsum_d   = rsum_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    flags_d  = flags_q;
    k_d      = k_q;
    addr_d   = addr_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    q_pop_o  = 1'b0;
    fr_we    = 1'b0;
    fr_waddr = rx_cnt_q[FrameAw-1:0];
    fr_raddr = ix12[FrameAw-1:0];
    tb_we    = 1'b0;
    tb_waddr = wa;
    tb_wdata = 8'h00;
    tb_raddr = wa;
    emit     = 1'b0;
    emit_byte = err_q;
    n        = {1'b0, rx_cnt_q} + 9'd1;
    f1       = (rx_cnt_q == 8'd1) ? b : fb1_q;
    f2       = (rx_cnt_q == 8'd2) ? b : fb2_q;
    wval     = (((9'd6 + {1'b0, k_q}) < {1'b0, len_q}) ? fr_rdata : 8'h00) - BIAS;

    case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.op)
            OP_CLEAR: begin
              q_pop_o  = 1'b1;
              rx_cnt_d = 8'd0;
            end
            OP_RX: begin
              q_pop_o = 1'b1;
              if (rx_cnt_q == 8'd0) begin
                if (b == SOF) begin
                  fr_we    = 1'b1;
                  rx_cnt_d = 8'd1;
                  sum_d    = b;
                  for (int i = 0; i < 6; i++) begin
                    d_d[i] = 8'h00;
                  end
                end
              end else begin
                fr_we = 1'b1;
                sum_d = sum_q + b;
                case (rx_cnt_q)
                  8'd1:    fb1_d = b;
                  8'd2:    fb2_d = b;
                  8'd4:    cmd_d = b;
                  8'd5:    len_d = b;
                  default: ;
                endcase
                if (rx_cnt_q >= 8'd6 && rx_cnt_q < 8'd12 &&
                    {1'b0, rx_cnt_q} < ({1'b0, len_q} + 9'd6)) begin
                  d_d[3'(rx_cnt_q - 8'd6)] = b;
                end
                if (rx_cnt_q >= 8'd6 && {1'b0, rx_cnt_q} == ({1'b0, len_q} + 9'd6)) begin
                  chk_d = (b == sum_q);
                end
                if (n > 9'(FrameBytes - 2)) begin
                  rx_cnt_d = 8'd0;
                end else if (rx_cnt_q >= 8'd2 && (f1 != ADDR0 || f2 != ADDR1)) begin
                  rx_cnt_d = 8'd0;
                end else if (b == EOF_MARK && n >= 9'd8 &&
                             n == ({1'b0, len_q} + 9'd8)) begin
                  rx_cnt_d = 8'd0;
                  if (chk_q) begin
                    case (cmd_q)
                      CMD_RESET: begin
                        code_d  = CMD_RESET;
                        start_d = 8'h00;
                        rlen_d  = 8'h00;
                        err_d   = 8'h00;
                        rsum_d  = HDR_SUM + CMD_RESET;
                        pos_d   = 9'd0;
                        pend_d  = 1'b1;
                      end
                      CMD_READ: begin
                        if (({1'b0, rd_addr} + {1'b0, rd_cnt}) >= 9'(TABLE_BYTES)) begin
                          code_d  = RSP_RD_ERR;
                          start_d = 8'h00;
                          rlen_d  = 8'h01;
                          err_d   = ERR_RANGE;
                          rsum_d  = HDR_SUM + RSP_RD_ERR + 8'h01 + ERR_RANGE;
                          pos_d   = 9'd0;
                          pend_d  = 1'b1;
                        end else begin
                          addr_d = rd_addr;
                          cnt_d  = rd_cnt;
                          k_d    = 8'd0;
                          acc_d  = HDR_SUM + RSP_READ + rd_cnt;
                          st_d   = S_SUM_RD;
                        end
                      end
                      CMD_WRITE: begin
                        if (({1'b0, rd_addr} + {1'b0, rd_cnt}) > 9'(TABLE_BYTES)) begin
                          code_d  = RSP_WR_ERR;
                          start_d = 8'h00;
                          rlen_d  = 8'h01;
                          err_d   = ERR_RANGE;
                          rsum_d  = HDR_SUM + RSP_WR_ERR + 8'h01 + ERR_RANGE;
                          pos_d   = 9'd0;
                          pend_d  = 1'b1;
                        end else begin
                          addr_d = rd_addr;
                          cnt_d  = rd_cnt;
                          k_d    = 8'd0;
                          st_d   = S_PW_RD;
                        end
                      end
                      default: ;
                    endcase
                  end
                end else begin
                  rx_cnt_d = n[7:0];
                end
              end
            end
            OP_FETCH: begin
              if (!out_vq) begin
                q_pop_o = 1'b1;
                if (pend_q && code_q == RSP_READ && pos_q >= 9'd6 &&
                    pos_q < ({1'b0, rlen_q} + 9'd6)) begin
                  tb_raddr = start_q + 8'(pos_q - 9'd6);
                  st_d     = S_TX_OUT;
                end else begin
                  emit = 1'b1;
                end
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      S_SUM_RD: begin
        if (k_q == cnt_q) begin
          code_d  = RSP_READ;
          start_d = addr_q;
          rlen_d  = cnt_q;
          err_d   = 8'h00;
          rsum_d  = acc_q;
          pos_d   = 9'd0;
          pend_d  = 1'b1;
          st_d    = S_IDLE;
        end else begin
          st_d = S_SUM_ACC;
        end
      end
      S_SUM_ACC: begin
        acc_d = acc_q + tb_data + BIAS;
        k_d   = k_q + 8'd1;
        st_d  = S_SUM_RD;
      end
      S_PW_RD: begin
        if (k_q == 8'd4) begin
          k_d  = 8'd0;
          st_d = S_WR_RD;
        end else begin
          tb_raddr = 8'(PASSWORD_OFFSET) + k_q;
          st_d     = S_PW_CHK;
        end
      end
      S_PW_CHK: begin
        if ((d_q[3'(k_q[1:0]) + 3'd2] - BIAS) != tb_data) begin
          code_d  = RSP_WR_ERR;
          start_d = 8'h00;
          rlen_d  = 8'h01;
          err_d   = ERR_PASSWD;
          rsum_d  = HDR_SUM + RSP_WR_ERR + 8'h01 + ERR_PASSWD;
          pos_d   = 9'd0;
          pend_d  = 1'b1;
          st_d    = S_IDLE;
        end else begin
          k_d  = k_q + 8'd1;
          st_d = S_PW_RD;
        end
      end
      S_WR_RD: begin
        if (k_q == cnt_q) begin
          code_d  = RSP_WRITE;
          start_d = 8'h00;
          rlen_d  = 8'h00;
          err_d   = 8'h00;
          rsum_d  = HDR_SUM + RSP_WRITE;
          pos_d   = 9'd0;
          pend_d  = 1'b1;
          st_d    = S_IDLE;
        end else begin
          st_d = S_WR_DO;
        end
      end
      S_WR_DO: begin
        tb_we    = 1'b1;
        tb_wdata = wval;
        if (wa >= 8'd25 && wa <= 8'd38) begin
          flags_d[0] = 1'b1;
        end else if (wa >= 8'd193 && wa <= 8'd201) begin
          flags_d[2] = 1'b1;
        end else if (wa != 8'd209) begin
          flags_d[1] = 1'b1;
        end
        k_d  = k_q + 8'd1;
        st_d = S_WR_RD;
      end
      S_TX_OUT: begin
        emit      = 1'b1;
        emit_byte = tb_data + BIAS;
        st_d      = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase

    // reply byte generator
    out_vd      = out_vq;
    out_byte_d  = out_byte_q;
    out_tv_d    = out_tv_q;
    out_last_d  = out_last_q;
    out_flags_d = out_flags_q;
    if (out_vq && !out_stall_i) begin
      out_vd = 1'b0;
    end
    if (emit) begin
      out_vd      = 1'b1;
      out_byte_d  = 8'h00;
      out_tv_d    = pend_q;
      out_last_d  = 1'b0;
      out_flags_d = flags_q;
      if (pend_q) begin
        if (pos_q == 9'd0 || pos_q == 9'd3) begin
          out_byte_d = SOF;
        end else if (pos_q == 9'd1) begin
          out_byte_d = ADDR0;
        end else if (pos_q == 9'd2) begin
          out_byte_d = ADDR1;
        end else if (pos_q == 9'd4) begin
          out_byte_d = code_q;
        end else if (pos_q == 9'd5) begin
          out_byte_d = rlen_q;
        end else if (pos_q < ({1'b0, rlen_q} + 9'd6)) begin
          out_byte_d = emit_byte;
        end else if (pos_q == ({1'b0, rlen_q} + 9'd6)) begin
          out_byte_d = rsum_q;
        end else begin
          out_byte_d = EOF_MARK;
          out_last_d = 1'b1;
        end
        if (out_last_d) begin
          pend_d = 1'b0;
          pos_d  = 9'd0;
        end else begin
          pos_d = pos_q + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      rx_cnt_q <= 8'd0;
      code_q   <= 8'h00;
      start_q  <= 8'h00;
      rlen_q   <= 8'h00;
      err_q    <= 8'h00;
      rsum_q   <= 8'h00;
      pos_q    <= 9'd0;
      pend_q   <= 1'b0;
      flags_q  <= 3'd0;
      out_vq   <= 1'b0;
      tvr_q    <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        tv_q[i] <= 1'b0;
      end
    end else begin
      st_q     <= st_d;
      rx_cnt_q <= rx_cnt_d;
      code_q   <= code_d;
      start_q  <= start_d;
      rlen_q   <= rlen_d;
      err_q    <= err_d;
      rsum_q   <= rsum_d;
      pos_q    <= pos_d;
      pend_q   <= pend_d;
      flags_q  <= flags_d;
      out_vq   <= out_vd;
      tvr_q    <= tv_q[tb_raddr];
      if (tb_we) begin
        tv_q[tb_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fb1_q       <= fb1_d;
    fb2_q       <= fb2_d;
    cmd_q       <= cmd_d;
    len_q       <= len_d;
    sum_q       <= sum_d;
    chk_q       <= chk_d;
    d_q         <= d_d;
    k_q         <= k_d;
    addr_q      <= addr_d;
    cnt_q       <= cnt_d;
    acc_q       <= acc_d;
    out_byte_q  <= out_byte_d;
    out_tv_q    <= out_tv_d;
    out_last_q  <= out_last_d;
    out_flags_q <= out_flags_d;
  end

  assign out_valid_o  = out_vq;
  assign tx_byte_o    = out_byte_q;
  assign tx_valid_o   = out_tv_q;
  assign tx_last_o    = out_last_q;
  assign sync_flags_o = out_flags_q;

endmodule

`default_nettype wire

@@ hdl/framed_register_table_slave_unit.sv @@
// Top level of the framed register table slave: front queue plus back engine.
// Depends on frst_pkg, frst_front, frst_back (and frst_ram below it).
`default_nettype none

// Serial-line slave for frames 68 31 CE 68 cmd L data sum 16. Each word carries a
// command: receive a byte, fetch the next reply byte (one result word, tx_valid 0 if
// nothing is pending), or clear the receiver (command 3 is dropped). A two-deep queue
// takes words while the engine works. A read reply data byte also passes a state for
// the table RAM read, and a fetch waits while the previous reply word still sits in the
// output register. The byte that closes a frame runs the command over the parameter
// table: a read walks the requested entries to build the checksum, a write checks the
// four password bytes and then stores the entries. The table reads as zero after reset
// through per-entry valid bits; there is no clearing pass.
module framed_register_table_slave_unit #(
  parameter int FrameBytes = frst_pkg::FRAME_BYTES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] command_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      tx_byte_o,
  output logic            tx_valid_o,
  output logic            tx_last_o,
  output logic [2:0]      sync_flags_o
);
  import frst_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  frst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .rx_byte_i  (rx_byte_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  frst_back #(.FrameBytes(FrameBytes)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_byte_o    (tx_byte_o),
    .tx_valid_o   (tx_valid_o),
    .tx_last_o    (tx_last_o),
    .sync_flags_o (sync_flags_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_framed_register_table_slave_unit.sv @@
// Testbench for framed_register_table_slave_unit: directed frame table, then random frames.
// Checks every reply word against an in-bench model of the slave. Depends on frst_pkg.
`default_nettype none

module tb_framed_register_table_slave_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import frst_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] command_i = IN_RX;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] tx_byte_o;
  logic       tx_valid_o;
  logic       tx_last_o;
  logic [2:0] sync_flags_o;

  framed_register_table_slave_unit dut (.*);

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] b;
    logic       v;
    logic       l;
    logic [2:0] f;
  } reply_word_t;

  // slave model state
  logic [7:0] frm [FRAME_BYTES];
  logic [7:0] tbl [256];
  int unsigned rx_cnt, rsp_pos;
  logic [7:0] rsp_code, rsp_start, rsp_len, rsp_err, rsp_sum;
  bit         rsp_busy;
  logic [2:0] flags;

  reply_word_t reply_q[$];
  int  n_err = 0;
  int  cyc = 0;
  int  sent = 0;
  int  send_gap = 0, recv_gap = 0;

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %02h want %02h at cycle %0d", what, got, want, cyc);
    n_err++;
  endtask

  function automatic logic [7:0] data_at(int unsigned k);
    int unsigned len;
    len = frm[5];
    if (k >= len || 6 + k >= FRAME_BYTES) return 8'h00;
    return frm[6 + k];
  endfunction

  function automatic logic [7:0] rsp_data(int unsigned k);
    if (rsp_code == RSP_READ) return 8'(tbl[8'(rsp_start + k)] + BIAS);
    return rsp_err;
  endfunction

  function automatic void start_reply(logic [7:0] c, logic [7:0] st, logic [7:0] ln,
                                      logic [7:0] e);
    logic [7:0] s;
    rsp_code = c; rsp_start = st; rsp_len = ln; rsp_err = e;
    s = 8'(HDR_SUM + c + ln);
    for (int k = 0; k < ln; k++) s = 8'(s + rsp_data(k));
    rsp_sum = s; rsp_pos = 0; rsp_busy = 1;
  endfunction

  function automatic void run_frame();
    int unsigned len;
    logic [7:0] s, a, n;
    int unsigned ad;
    len = frm[5];
    s = 0;
    for (int k = 0; k < len + 6 && k < FRAME_BYTES; k++) s = 8'(s + frm[k]);
    if (len + 6 >= FRAME_BYTES || frm[len + 6] != s) return;
    a = 8'(data_at(0) - BIAS);
    n = 8'(data_at(1) - BIAS);
    if (frm[4] == CMD_READ) begin
      if (int'(a) + int'(n) >= TABLE_BYTES) start_reply(RSP_RD_ERR, 8'h00, 8'h01, ERR_RANGE);
      else start_reply(RSP_READ, a, n, 8'h00);
    end else if (frm[4] == CMD_WRITE) begin
      if (int'(a) + int'(n) > TABLE_BYTES) begin
        start_reply(RSP_WR_ERR, 8'h00, 8'h01, ERR_RANGE);
        return;
      end
      for (int k = 0; k < 4; k++)
        if (8'(data_at(2 + k) - BIAS) != tbl[8'(PASSWORD_OFFSET + k)]) begin
          start_reply(RSP_WR_ERR, 8'h00, 8'h01, ERR_PASSWD);
          return;
        end
      for (int k = 0; k < n; k++) begin
        ad = a + k;
        tbl[8'(ad)] = 8'(data_at(6 + k) - BIAS);
        if (ad >= 25 && ad <= 38) flags[0] = 1'b1;
        else if (ad >= 193 && ad <= 201) flags[2] = 1'b1;
        else if (ad != 209) flags[1] = 1'b1;
      end
      start_reply(RSP_WRITE, 8'h00, 8'h00, 8'h00);
    end else if (frm[4] == CMD_RESET) begin
      start_reply(CMD_RESET, 8'h00, 8'h00, 8'h00);
    end
  endfunction

  // advance the model by one accepted word; queue the reply word for a fetch
  function automatic void slave_step(logic [1:0] c, logic [7:0] b);
    reply_word_t w;
    int unsigned p;
    if (c == IN_RX) begin
      if (rx_cnt == 0) begin
        if (b == SOF) begin frm[0] = b; rx_cnt = 1; end
        return;
      end
      if (rx_cnt < FRAME_BYTES) frm[rx_cnt] = b;
      rx_cnt++;
      if (rx_cnt > FRAME_BYTES - 2) rx_cnt = 0;
      else if (rx_cnt >= 3 && (frm[1] != ADDR0 || frm[2] != ADDR1)) rx_cnt = 0;
      else if (b == EOF_MARK && rx_cnt >= 8 && rx_cnt == frm[5] + 8) begin
        rx_cnt = 0;
        run_frame();
      end
    end else if (c == IN_CLEAR) begin
      rx_cnt = 0;
    end else if (c == IN_FETCH) begin
      w = '0;
      if (rsp_busy) begin
        p = rsp_pos;
        w.v = 1;
        if (p == 0 || p == 3) w.b = SOF;
        else if (p == 1) w.b = ADDR0;
        else if (p == 2) w.b = ADDR1;
        else if (p == 4) w.b = rsp_code;
        else if (p == 5) w.b = rsp_len;
        else if (p < 6 + rsp_len) w.b = rsp_data(p - 6);
        else if (p == 6 + rsp_len) w.b = rsp_sum;
        else begin w.b = EOF_MARK; w.l = 1; end
        if (w.l) begin rsp_busy = 0; rsp_pos = 0; end
        else rsp_pos = (p + 1) & 9'h1FF;
      end
      w.f = flags;
      reply_q.push_back(w);
    end
  endfunction

  // send one word through the handshake; stall is sampled mid-cycle, where it is stable
  task automatic send(logic [1:0] c, logic [7:0] b);
    bit took;
    while ($urandom_range(99) < send_gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= c;
    rx_byte_i <= b;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end
    slave_step(c, b);
    sent++;
  endtask

  task automatic send_frame(logic [7:0] c, logic [7:0] body[$]);
    logic [7:0] s;
    logic [7:0] hdr[$];
    hdr = '{SOF, ADDR0, ADDR1, SOF, c, 8'(body.size())};
    s = 0;
    foreach (hdr[i]) begin s = 8'(s + hdr[i]); send(IN_RX, hdr[i]); end
    foreach (body[i]) begin s = 8'(s + body[i]); send(IN_RX, body[i]); end
    send(IN_RX, s);
    send(IN_RX, EOF_MARK);
  endtask

  task automatic drain_reply();
    int guard;
    guard = 0;
    while ((rsp_busy || guard == 0) && guard < 300) begin
      send(IN_FETCH, 8'($urandom));
      guard++;
    end
  endtask

  // receiver side
  always @(posedge clk_i) begin
    reply_word_t w;
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("framed_register_table_slave_unit test failed");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          report("unexpected word", tx_byte_o, 8'h00);
        end else begin
          w = reply_q.pop_front();
          if (tx_byte_o !== w.b) report("tx_byte", tx_byte_o, w.b);
          if (tx_valid_o !== w.v) report("tx_valid", 8'(tx_valid_o), 8'(w.v));
          if (tx_last_o !== w.l) report("tx_last", 8'(tx_last_o), 8'(w.l));
          if (sync_flags_o !== w.f) report("sync_flags", 8'(sync_flags_o), 8'(w.f));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_gap);
    end
  end

  typedef struct {
    logic [1:0] c;
    logic [7:0] b;
    bit         chk;
    logic [7:0] want;
  } row_t;

  function automatic logic [7:0] biased(int v);
    return 8'(v + BIAS);
  endfunction

  task automatic rand_frame();
    logic [7:0] body[$];
    int a, n, r;
    r = $urandom_range(99);
    a = $urandom_range(255);
    n = ($urandom_range(9) == 0) ? $urandom_range((256 - a) < 40 ? (256 - a) : 40) :
                                   $urandom_range(6);
    body = '{biased(a), biased(n)};
    if (r < 35) begin
      send_frame(CMD_READ, body);
    end else if (r < 75) begin
      for (int k = 0; k < 4; k++)
        body.push_back($urandom_range(7) == 0 ? 8'($urandom) :
                       biased(tbl[PASSWORD_OFFSET + k]));
      for (int k = 0; k < n; k++) body.push_back(8'($urandom));
      send_frame(CMD_WRITE, body);
    end else if (r < 80) begin
      send_frame(CMD_RESET, '{});
    end else if (r < 85) begin
      send_frame(8'($urandom), body);
    end else begin
      // noise and broken frames
      repeat ($urandom_range(1, 8))
        send(2'($urandom_range(3)), ($urandom_range(3) == 0) ? SOF : 8'($urandom));
    end
    if ($urandom_range(3) != 0) drain_reply();
  endtask

  row_t rows[$];
  int   words;

  initial begin
    for (int i = 0; i < FRAME_BYTES; i++) frm[i] = 0;
    for (int i = 0; i < 256; i++) tbl[i] = 0;
    rx_cnt = 0; rsp_pos = 0; rsp_busy = 0; flags = 0;
    rsp_code = 0; rsp_start = 0; rsp_len = 0; rsp_err = 0; rsp_sum = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fetch after reset, idle noise, clear, then a read range error frame
    rows = '{
      '{IN_FETCH, 8'hFF, 1, 8'h00},
      '{IN_RX, 8'h00, 0, 0}, '{IN_RX, 8'hFF, 0, 0}, '{IN_NOP, 8'h68, 0, 0},
      '{IN_RX, SOF, 0, 0}, '{IN_RX, 8'h30, 0, 0}, '{IN_CLEAR, 8'h00, 0, 0},
      '{IN_RX, SOF, 0, 0}, '{IN_RX, ADDR0, 0, 0}, '{IN_RX, ADDR1, 0, 0},
      '{IN_RX, SOF, 0, 0}, '{IN_RX, CMD_READ, 0, 0}, '{IN_RX, 8'h02, 0, 0},
      '{IN_RX, 8'h32, 0, 0}, '{IN_RX, 8'h34, 0, 0}, '{IN_RX, 8'h39, 0, 0},
      '{IN_RX, EOF_MARK, 0, 0},
      '{IN_FETCH, 0, 1, SOF}, '{IN_FETCH, 0, 1, ADDR0}, '{IN_FETCH, 0, 1, ADDR1},
      '{IN_FETCH, 0, 1, SOF}, '{IN_FETCH, 0, 1, RSP_RD_ERR}, '{IN_FETCH, 0, 1, 8'h01},
      '{IN_FETCH, 0, 1, ERR_RANGE}
    };
    foreach (rows[i]) begin
      send(rows[i].c, rows[i].b);
      if (rows[i].chk && reply_q[$].b !== rows[i].want)
        report("directed row", reply_q[$].b, rows[i].want);
    end
    drain_reply();
    // write with good and bad password, write range error, long read, reset ack
    send_frame(CMD_WRITE, '{biased(0), biased(4), biased(0), biased(0), biased(0),
                            biased(0), 8'h11, 8'h22, 8'h33, 8'h44});
    drain_reply();
    send_frame(CMD_WRITE, '{biased(25), biased(1), biased(0), biased(0), biased(0),
                            biased(0), 8'hFF});
    drain_reply();
    send_frame(CMD_WRITE, '{biased(200), biased(2), 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                            8'h02});
    drain_reply();
    send_frame(CMD_WRITE, '{biased(255), biased(2)});
    drain_reply();
    send_frame(CMD_READ, '{biased(200), biased(55)});
    drain_reply();
    send_frame(CMD_RESET, '{});
    drain_reply();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap = (ph == 0) ? 7 : (ph == 1) ? 61 : 0;
      recv_gap = (ph == 0) ? 61 : (ph == 1) ? 7 : 0;
      words = sent + 115;
      while (sent < words) rand_frame();
    end
    send_gap = 0;
    in_valid_i <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (n_err == 0) $display("framed_register_table_slave_unit test passed");
    else $display("framed_register_table_slave_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
